### src/cscc_pkg.sv
// Shared types and constants for the chunk stream continuity checker.
// Holds the item structs, verdict and reason codes and register indexes.
// No dependencies.
package cscc_pkg;

	// Longest name a slot header may declare.
	localparam logic [7:0] NAME_LIMIT = 8'd23;

	// Depth of the queue between the classifier and the tracker.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAM_HEADER_LEN = 3'd4;
	localparam int CFG_DATA_W = 32;

	// Reset values of the configuration registers.
	localparam logic [7:0]  RST_EXPECTED_VERSION  = 8'd1;
	localparam logic [15:0] RST_HEADER_BYTES      = 16'd64;
	localparam logic [15:0] RST_PAYLOAD_LIMIT     = 16'd4032;
	localparam logic [31:0] RST_FILE_SIZE_LIMIT   = 32'd2097152;
	localparam logic [15:0] RST_STREAM_HEADER_LEN = 16'd40;

	// Item operation codes.
	typedef enum logic {
		OP_CHECK = 1'b0,
		OP_ABORT = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		VERDICT_FORWARDED = 3'd0,
		VERDICT_DISCARDED = 3'd1,
		VERDICT_START_IGN = 3'd2,
		VERDICT_UNROUTED  = 3'd3,
		VERDICT_TOO_SHORT = 3'd4
	} verdict_t;

	typedef enum logic [3:0] {
		REASON_NONE        = 4'd0,
		REASON_VERSION     = 4'd1,
		REASON_PAYLOAD     = 4'd2,
		REASON_NAME        = 4'd3,
		REASON_ZERO_SESS   = 4'd4,
		REASON_CRC         = 4'd5,
		REASON_IDENTITY    = 4'd6,
		REASON_ORDER       = 4'd7,
		REASON_OVERRUN     = 4'd8,
		REASON_END_SHORT   = 4'd9,
		REASON_END_MISSING = 4'd10
	} reason_t;

	// Bit positions within side_bits.
	localparam int SIDE_START    = 0;
	localparam int SIDE_END      = 1;
	localparam int SIDE_CRC_OK   = 2;
	localparam int SIDE_ROUTABLE = 3;
	localparam int SIDE_ABORT_CT = 4;

	typedef struct packed {
		logic        op;
		logic [15:0] slot_len;
		logic [7:0]  version;
		logic [15:0] header_size_field;
		logic [31:0] session;
		logic [31:0] stream_total;
		logic [31:0] chunk_offset;
		logic [15:0] payload_length;
		logic [15:0] chunk_index;
		logic [15:0] chunk_total;
		logic [7:0]  name_length;
		logic [4:0]  side_bits;
	} in_item_t;

	typedef struct packed {
		verdict_t    verdict;
		reason_t     reason;
		logic        open_file_dropped;
		logic        first_chunk;
		logic        file_complete;
		logic [31:0] slot_count;
		logic [31:0] good_file_count;
		logic [31:0] dropped_file_count;
		logic [31:0] unrouted_count;
	} out_item_t;

	// Configuration as seen by the classifier.
	typedef struct packed {
		logic [7:0]  expected_version;
		logic [15:0] header_bytes;
		logic [15:0] payload_limit;
		logic [31:0] file_size_limit;
		logic [15:0] stream_header_len;
	} cfg_t;

	// Classified item handed from the front to the tracker.
	typedef struct packed {
		logic        is_abort;
		logic        abort_counts;
		logic        too_short;
		reason_t     hdr_reason;
		logic        start_slot;
		logic        is_end;
		logic        routable;
		logic        start_bad;
		logic [31:0] session;
		logic [31:0] stream_total;
		logic [31:0] chunk_offset;
		logic [15:0] payload_length;
		logic [15:0] chunk_index;
		logic [15:0] chunk_total;
		logic [32:0] end_pos;
	} cls_t;

endpackage

### src/cscc_front.sv
// Front end of the checker: runs the stateless header checks on each item.
// Produces a classified record for the tracker queue.
// Depends on cscc_pkg.
module cscc_front import cscc_pkg::*; (
	input  in_item_t item,
	input  cfg_t     cfg,
	output cls_t     cls
);

	logic [16:0] hdr_plus_payload;
	logic [32:0] total_limit;
	logic        bad_version;
	logic        bad_payload;
	reason_t     hdr_reason;

	// Sums are formed one bit wider so they never wrap.
	assign hdr_plus_payload = {1'b0, cfg.header_bytes} + {1'b0, item.payload_length};
	assign total_limit      = {1'b0, cfg.file_size_limit} + {17'd0, cfg.stream_header_len};

	assign bad_version = (item.version != cfg.expected_version) ||
		(item.header_size_field != cfg.header_bytes);
	assign bad_payload = (item.payload_length == 16'd0) ||
		(item.payload_length > cfg.payload_limit) ||
		(hdr_plus_payload > {1'b0, item.slot_len});

	// Header checks in priority order.
	always_comb begin
		if (bad_version) begin
			hdr_reason = REASON_VERSION;
		end else if (bad_payload) begin
			hdr_reason = REASON_PAYLOAD;
		end else if (item.name_length > NAME_LIMIT) begin
			hdr_reason = REASON_NAME;
		end else if (item.session == 32'd0) begin
			hdr_reason = REASON_ZERO_SESS;
		end else if (!item.side_bits[SIDE_CRC_OK]) begin
			hdr_reason = REASON_CRC;
		end else begin
			hdr_reason = REASON_NONE;
		end
	end

	assign cls.hdr_reason = hdr_reason;

	// A start must begin at zero and declare a total within the file limits.
	assign cls.start_bad = (item.chunk_offset != 32'd0) || (item.chunk_index != 16'd0) ||
		(item.stream_total <= {16'd0, cfg.stream_header_len}) ||
		({1'b0, item.stream_total} > total_limit);

	assign cls.is_abort       = (item.op == OP_ABORT);
	assign cls.abort_counts   = item.side_bits[SIDE_ABORT_CT];
	assign cls.too_short      = (item.slot_len < cfg.header_bytes);
	assign cls.start_slot     = item.side_bits[SIDE_START];
	assign cls.is_end         = item.side_bits[SIDE_END];
	assign cls.routable       = item.side_bits[SIDE_ROUTABLE];
	assign cls.session        = item.session;
	assign cls.stream_total   = item.stream_total;
	assign cls.chunk_offset   = item.chunk_offset;
	assign cls.payload_length = item.payload_length;
	assign cls.chunk_index    = item.chunk_index;
	assign cls.chunk_total    = item.chunk_total;
	assign cls.end_pos        = {1'b0, item.chunk_offset} + {17'd0, item.payload_length};

endmodule

### src/cscc_queue.sv
// Short queue of classified items between the front end and the tracker.
// Register-based circular buffer with valid/ready on both sides.
// Depends on cscc_pkg.
module cscc_queue import cscc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cls_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cls_t pop_data
);

	localparam logic [QUEUE_PTR_W-1:0] LAST_PTR = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QUEUE_CNT_W-1:0] FULL_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);

	cls_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### src/cscc_back.sv
// Back end of the checker: tracks the open file, keeps the lifetime counters
// and registers one result per classified item. Depends on cscc_pkg.
module cscc_back import cscc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cls_valid,
	output logic      cls_ready,
	input  cls_t      cls,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic        file_open_q;
	logic [31:0] tracked_session_q;
	logic [31:0] tracked_total_q;
	logic [15:0] tracked_chunks_q;
	logic [31:0] expected_offset_q;
	logic [15:0] expected_index_q;
	logic [31:0] slots_seen_q;
	logic [31:0] files_good_q;
	logic [31:0] files_dropped_q;
	logic [31:0] slots_unrouted_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        take;
	logic        nx_open;
	logic [31:0] nx_session;
	logic [31:0] nx_total;
	logic [15:0] nx_chunks;
	logic [31:0] nx_offset;
	logic [15:0] nx_index;
	logic        inc_slot;
	logic        inc_good;
	logic        inc_unrouted;
	logic [1:0]  inc_drop;
	verdict_t    verdict;
	reason_t     reason;
	logic        dropped;
	logic        first;
	logic        complete;
	logic [31:0] nx_slots;
	logic [31:0] nx_good;
	logic [31:0] nx_dropped;
	logic [31:0] nx_unrouted;

	// A new item enters whenever the result register is free or being emptied.
	assign take      = cls_valid && (!out_valid_q || out_ready);
	assign cls_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Tracking decision for one classified item.
	always_comb begin
		logic        go_on;
		logic [31:0] b_session;
		logic [31:0] b_total;
		logic [15:0] b_chunks;
		logic [31:0] b_offset;
		logic [15:0] b_index;
		logic [32:0] total_ext;

		go_on        = 1'b0;
		b_session    = tracked_session_q;
		b_total      = tracked_total_q;
		b_chunks     = tracked_chunks_q;
		b_offset     = expected_offset_q;
		b_index      = expected_index_q;
		nx_open      = file_open_q;
		nx_session   = tracked_session_q;
		nx_total     = tracked_total_q;
		nx_chunks    = tracked_chunks_q;
		nx_offset    = expected_offset_q;
		nx_index     = expected_index_q;
		inc_slot     = 1'b0;
		inc_good     = 1'b0;
		inc_unrouted = 1'b0;
		inc_drop     = 2'd0;
		verdict      = VERDICT_FORWARDED;
		reason       = REASON_NONE;
		dropped      = 1'b0;
		first        = 1'b0;
		complete     = 1'b0;

		if (cls.is_abort) begin
			// Abort always clears tracking; it counts only when asked to.
			dropped = file_open_q;
			if (file_open_q && cls.abort_counts) begin
				inc_drop = 2'd1;
			end
			nx_open = 1'b0;
		end else if (cls.too_short) begin
			verdict = VERDICT_TOO_SHORT;
		end else begin
			inc_slot = 1'b1;
			if (cls.hdr_reason != REASON_NONE) begin
				verdict  = VERDICT_DISCARDED;
				reason   = cls.hdr_reason;
				dropped  = file_open_q;
				inc_drop = {1'b0, file_open_q};
				nx_open  = 1'b0;
			end else if (cls.start_slot) begin
				// A start abandons any open file before it is judged.
				dropped  = file_open_q;
				inc_drop = {1'b0, file_open_q};
				nx_open  = 1'b0;
				if (cls.start_bad) begin
					verdict = VERDICT_START_IGN;
				end else if (!cls.routable) begin
					verdict      = VERDICT_UNROUTED;
					inc_unrouted = 1'b1;
				end else begin
					go_on     = 1'b1;
					b_session = cls.session;
					b_total   = cls.stream_total;
					b_chunks  = cls.chunk_total;
					b_offset  = 32'd0;
					b_index   = 16'd0;
				end
			end else if (!file_open_q) begin
				verdict      = VERDICT_UNROUTED;
				inc_unrouted = 1'b1;
			end else begin
				go_on = 1'b1;
			end
		end

		// Continuity checks against the tracked (or just opened) file.
		total_ext = {1'b0, b_total};
		if (go_on) begin
			if (cls.session != b_session || cls.stream_total != b_total ||
					cls.chunk_total != b_chunks) begin
				reason = REASON_IDENTITY;
			end else if (cls.chunk_offset != b_offset || cls.chunk_index != b_index) begin
				reason = REASON_ORDER;
			end else if (cls.end_pos > total_ext) begin
				reason = REASON_OVERRUN;
			end else if (cls.is_end && cls.end_pos != total_ext) begin
				reason = REASON_END_SHORT;
			end else if (!cls.is_end && cls.end_pos == total_ext) begin
				reason = REASON_END_MISSING;
			end

			if (reason != REASON_NONE) begin
				verdict  = VERDICT_DISCARDED;
				dropped  = 1'b1;
				inc_drop = inc_drop + 2'd1;
				nx_open  = 1'b0;
			end else begin
				verdict    = VERDICT_FORWARDED;
				first      = cls.start_slot;
				nx_open    = !cls.is_end;
				nx_session = b_session;
				nx_total   = b_total;
				nx_chunks  = b_chunks;
				nx_offset  = b_offset + {16'd0, cls.payload_length};
				nx_index   = b_index + 16'd1;
				if (cls.is_end) begin
					inc_good = 1'b1;
					complete = 1'b1;
				end
			end
		end

		// A closed file leaves the tracking fields cleared.
		if (!nx_open) begin
			nx_session = 32'd0;
			nx_total   = 32'd0;
			nx_chunks  = 16'd0;
			nx_offset  = 32'd0;
			nx_index   = 16'd0;
		end
	end

	assign nx_slots    = slots_seen_q + {31'd0, inc_slot};
	assign nx_good     = files_good_q + {31'd0, inc_good};
	assign nx_dropped  = files_dropped_q + {30'd0, inc_drop};
	assign nx_unrouted = slots_unrouted_q + {31'd0, inc_unrouted};

	// Tracking state, counters and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_open_q       <= 1'b0;
			tracked_session_q <= '0;
			tracked_total_q   <= '0;
			tracked_chunks_q  <= '0;
			expected_offset_q <= '0;
			expected_index_q  <= '0;
			slots_seen_q      <= '0;
			files_good_q      <= '0;
			files_dropped_q   <= '0;
			slots_unrouted_q  <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (take) begin
				file_open_q       <= nx_open;
				tracked_session_q <= nx_session;
				tracked_total_q   <= nx_total;
				tracked_chunks_q  <= nx_chunks;
				expected_offset_q <= nx_offset;
				expected_index_q  <= nx_index;
				slots_seen_q      <= nx_slots;
				files_good_q      <= nx_good;
				files_dropped_q   <= nx_dropped;
				slots_unrouted_q  <= nx_unrouted;
				out_valid_q       <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (take) begin
			out_q.verdict            <= verdict;
			out_q.reason             <= reason;
			out_q.open_file_dropped  <= dropped;
			out_q.first_chunk        <= first;
			out_q.file_complete      <= complete;
			out_q.slot_count         <= nx_slots;
			out_q.good_file_count    <= nx_good;
			out_q.dropped_file_count <= nx_dropped;
			out_q.unrouted_count     <= nx_unrouted;
		end
	end

endmodule

### src/chunk_stream_continuity_checker_unit.sv
// Chunk stream continuity checker, top level: configuration registers,
// header classifier, item queue and file tracker. Depends on cscc_pkg.
// With the queue empty, an accepted item is written into the queue and then
// registered into the result register. Throughput: one item per cycle while
// the sink keeps taking results. Reset (arst_n low) clears tracking, counters
// and the queue and returns the registers to their default values.
module chunk_stream_continuity_checker_unit import cscc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	cls_t front_cls;
	cls_t queue_cls;
	logic queue_valid;
	logic queue_ready;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version  <= RST_EXPECTED_VERSION;
			cfg_q.header_bytes      <= RST_HEADER_BYTES;
			cfg_q.payload_limit     <= RST_PAYLOAD_LIMIT;
			cfg_q.file_size_limit   <= RST_FILE_SIZE_LIMIT;
			cfg_q.stream_header_len <= RST_STREAM_HEADER_LEN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPECTED_VERSION: begin
					cfg_q.expected_version <= cfg_wdata[7:0];
				end
				CFG_HEADER_BYTES: begin
					cfg_q.header_bytes <= cfg_wdata[15:0];
				end
				CFG_PAYLOAD_LIMIT: begin
					cfg_q.payload_limit <= cfg_wdata[15:0];
				end
				CFG_FILE_SIZE_LIMIT: begin
					cfg_q.file_size_limit <= cfg_wdata[31:0];
				end
				CFG_STREAM_HEADER_LEN: begin
					cfg_q.stream_header_len <= cfg_wdata[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	cscc_front u_front (
		.item (in_data),
		.cfg  (cfg_q),
		.cls  (front_cls)
	);

	cscc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (front_cls),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_data   (queue_cls)
	);

	cscc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (queue_valid),
		.cls_ready (queue_ready),
		.cls       (queue_cls),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### bench/chunk_stream_continuity_checker_unit_tb.sv
// Self-checking testbench for chunk_stream_continuity_checker_unit.
// Drives slot headers and aborts through a bursty source and a stalling sink and
// checks every result against a cycle-free predictor. Depends on cscc_pkg.
module chunk_stream_continuity_checker_unit_tb;
	import cscc_pkg::*;

	// Defects that may be planted in one slot of a generated file.
	typedef enum int {
		FLAW_VERSION,
		FLAW_HDR_SIZE,
		FLAW_ZERO_PAY,
		FLAW_BIG_PAY,
		FLAW_PAY_FIT,
		FLAW_NAME,
		FLAW_ZERO_SESS,
		FLAW_CRC,
		FLAW_SESSION,
		FLAW_TOTAL,
		FLAW_COUNT,
		FLAW_OFFSET,
		FLAW_INDEX,
		FLAW_END_FLIP,
		FLAW_START_FLIP,
		FLAW_UNROUTED,
		FLAW_TOO_SHORT,
		FLAW_ABORT,
		FLAW_TAIL
	} flaw_t;

	// Sink behavior, picked at random each time the current mode runs out.
	typedef enum int {
		DRAIN_FULL,
		DRAIN_RANDOM,
		DRAIN_PATTERN
	} drain_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_EXPECTED_VERSION;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	chunk_stream_continuity_checker_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Register copies used by the predictor and by the item generator.
	logic [7:0]  reg_version     = RST_EXPECTED_VERSION;
	logic [15:0] reg_hdr_bytes   = RST_HEADER_BYTES;
	logic [15:0] reg_payload_max = RST_PAYLOAD_LIMIT;
	logic [31:0] reg_file_max    = RST_FILE_SIZE_LIMIT;
	logic [15:0] reg_stream_hdr  = RST_STREAM_HEADER_LEN;

	// Predicted tracking state and lifetime counters.
	logic        trk_open = 1'b0;
	logic [31:0] trk_session = '0;
	logic [31:0] trk_total = '0;
	logic [15:0] trk_chunks = '0;
	logic [31:0] trk_offset = '0;
	logic [15:0] next_index = '0;
	logic [31:0] cnt_slots = '0;
	logic [31:0] cnt_good = '0;
	logic [31:0] cnt_dropped = '0;
	logic [31:0] cnt_unrouted = '0;

	in_item_t  slot_items[$];
	out_item_t pending_results[$];
	int        items_made = 0;
	int        mismatch_count = 0;
	int        result_num = 0;

	// Source pacing and sink stall state.
	int          burst_left = 0;
	int          gap_left = 0;
	drain_mode_t drain_mode = DRAIN_FULL;
	int          drain_left = 0;
	logic [7:0]  drain_mask = 8'hFF;
	logic [2:0]  drain_beat = '0;

	// Clock.
	initial begin
		forever #4 clk = ~clk;
	end

	// Reset is held low from the start and released at a clock edge.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Prediction
	function automatic void forget_file();
		trk_open = 1'b0;
		trk_session = '0;
		trk_total = '0;
		trk_chunks = '0;
		trk_offset = '0;
		next_index = '0;
	endfunction

	// Abandons the open file, counting it; returns whether one was open.
	function automatic logic abandon_file();
		logic was_open;
		was_open = trk_open;
		if (trk_open) begin
			cnt_dropped++;
		end
		forget_file();
		return was_open;
	endfunction

	// Works out the result of one accepted item and advances the tracking state.
	function automatic out_item_t judge_item(in_item_t it);
		out_item_t   r;
		logic [32:0] end_pos;
		logic [32:0] start_cap;
		logic        start_slot;
		logic        is_end;
		logic        go_on;
		r = '0;
		r.verdict = VERDICT_FORWARDED;
		r.reason = REASON_NONE;
		start_slot = it.side_bits[SIDE_START];
		is_end = it.side_bits[SIDE_END];
		end_pos = {1'b0, it.chunk_offset} + {17'd0, it.payload_length};
		start_cap = {1'b0, reg_file_max} + {17'd0, reg_stream_hdr};
		if (it.op == OP_ABORT) begin
			r.open_file_dropped = trk_open;
			if (it.side_bits[SIDE_ABORT_CT]) begin
				void'(abandon_file());
			end else begin
				forget_file();
			end
		end else if (it.slot_len < reg_hdr_bytes) begin
			r.verdict = VERDICT_TOO_SHORT;
		end else begin
			cnt_slots++;
			// Header checks, first failure wins.
			if (it.version != reg_version || it.header_size_field != reg_hdr_bytes) begin
				r.reason = REASON_VERSION;
			end else if (it.payload_length == '0 || it.payload_length > reg_payload_max ||
					{1'b0, reg_hdr_bytes} + {1'b0, it.payload_length} > {1'b0, it.slot_len}) begin
				r.reason = REASON_PAYLOAD;
			end else if (it.name_length > NAME_LIMIT) begin
				r.reason = REASON_NAME;
			end else if (it.session == '0) begin
				r.reason = REASON_ZERO_SESS;
			end else if (!it.side_bits[SIDE_CRC_OK]) begin
				r.reason = REASON_CRC;
			end
			if (r.reason != REASON_NONE) begin
				r.verdict = VERDICT_DISCARDED;
				r.open_file_dropped = abandon_file();
			end else begin
				go_on = 1'b1;
				// A start replaces any open file, then is judged on its own.
				if (start_slot) begin
					if (trk_open) begin
						r.open_file_dropped = abandon_file();
					end
					if (it.chunk_offset != '0 || it.chunk_index != '0 ||
							it.stream_total <= {16'd0, reg_stream_hdr} ||
							{1'b0, it.stream_total} > start_cap) begin
						r.verdict = VERDICT_START_IGN;
						go_on = 1'b0;
					end else if (!it.side_bits[SIDE_ROUTABLE]) begin
						cnt_unrouted++;
						r.verdict = VERDICT_UNROUTED;
						go_on = 1'b0;
					end else begin
						trk_open = 1'b1;
						trk_session = it.session;
						trk_total = it.stream_total;
						trk_chunks = it.chunk_total;
						trk_offset = '0;
						next_index = '0;
					end
				end else if (!trk_open) begin
					cnt_unrouted++;
					r.verdict = VERDICT_UNROUTED;
					go_on = 1'b0;
				end
				// Continuity checks against the tracked file.
				if (go_on) begin
					if (it.session != trk_session || it.stream_total != trk_total ||
							it.chunk_total != trk_chunks) begin
						r.reason = REASON_IDENTITY;
					end else if (it.chunk_offset != trk_offset ||
							it.chunk_index != next_index) begin
						r.reason = REASON_ORDER;
					end else if (end_pos > {1'b0, trk_total}) begin
						r.reason = REASON_OVERRUN;
					end else if (is_end && end_pos != {1'b0, trk_total}) begin
						r.reason = REASON_END_SHORT;
					end else if (!is_end && end_pos == {1'b0, trk_total}) begin
						r.reason = REASON_END_MISSING;
					end
					if (r.reason != REASON_NONE) begin
						r.verdict = VERDICT_DISCARDED;
						r.open_file_dropped = abandon_file();
					end else begin
						r.first_chunk = start_slot;
						trk_offset += {16'd0, it.payload_length};
						next_index += 16'd1;
						if (is_end) begin
							cnt_good++;
							r.file_complete = 1'b1;
							forget_file();
						end
					end
				end
			end
		end
		r.slot_count = cnt_slots;
		r.good_file_count = cnt_good;
		r.dropped_file_count = cnt_dropped;
		r.unrouted_count = cnt_unrouted;
		return r;
	endfunction

	// Item generation
	function automatic void push_item(in_item_t it);
		slot_items.push_back(it);
		items_made++;
	endfunction

	// A slot whose header passes every check under the current registers.
	function automatic in_item_t make_slot(logic [31:0] sess, logic [31:0] total,
			logic [31:0] offset, logic [15:0] psize, logic [15:0] idx, logic [15:0] count,
			logic is_first, logic is_last);
		in_item_t    it;
		logic [16:0] room;
		room = {1'b0, reg_hdr_bytes} + {1'b0, psize};
		if ($urandom_range(0, 3) == 0) begin
			room += 17'($urandom_range(1, 300));
		end
		it.op = OP_CHECK;
		it.slot_len = (room > 17'h0FFFF) ? 16'hFFFF : room[15:0];
		it.version = reg_version;
		it.header_size_field = reg_hdr_bytes;
		it.session = sess;
		it.stream_total = total;
		it.chunk_offset = offset;
		it.payload_length = psize;
		it.chunk_index = idx;
		it.chunk_total = count;
		it.name_length = 8'($urandom_range(0, 23));
		it.side_bits = '0;
		it.side_bits[SIDE_START] = is_first;
		it.side_bits[SIDE_END] = is_last;
		it.side_bits[SIDE_CRC_OK] = 1'b1;
		it.side_bits[SIDE_ROUTABLE] = is_first ? 1'b1 : 1'($urandom_range(0, 1));
		it.side_bits[SIDE_ABORT_CT] = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// Random fields throughout; half the time the header identity is made right.
	function automatic in_item_t noise_item();
		in_item_t it;
		it.op = OP_CHECK;
		it.slot_len = 16'($urandom);
		it.version = 8'($urandom);
		it.header_size_field = 16'($urandom);
		it.session = $urandom;
		it.stream_total = $urandom;
		it.chunk_offset = $urandom;
		it.payload_length = 16'($urandom);
		it.chunk_index = 16'($urandom);
		it.chunk_total = 16'($urandom);
		it.name_length = 8'($urandom);
		it.side_bits = 5'($urandom);
		if ($urandom_range(0, 1) == 1) begin
			it.version = reg_version;
			it.header_size_field = reg_hdr_bytes;
		end
		return it;
	endfunction

	function automatic in_item_t abort_item(logic counts);
		in_item_t it;
		it = noise_item();
		it.op = OP_ABORT;
		it.side_bits[SIDE_ABORT_CT] = counts;
		return it;
	endfunction

	// One file as a start, continuations and an end, sometimes with a defect.
	task automatic queue_file();
		logic [15:0] sizes[$];
		logic [31:0] sess;
		logic [31:0] total;
		logic [31:0] offset;
		logic [15:0] count;
		in_item_t    it;
		flaw_t       flaw;
		int          max_pay;
		int          n;
		int          sz;
		int          flaw_at;
		int          need;
		max_pay = int'(reg_payload_max);
		if (65535 - int'(reg_hdr_bytes) < max_pay) begin
			max_pay = 65535 - int'(reg_hdr_bytes);
		end
		if (max_pay < 1) begin
			push_item(noise_item());
			return;
		end
		n = $urandom_range(1, 6);
		total = '0;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 5))
				0, 1, 2: sz = $urandom_range(1, (max_pay < 64) ? max_pay : 64);
				3, 4: sz = $urandom_range(1, max_pay);
				default: sz = max_pay;
			endcase
			sizes.push_back(16'(sz));
			total += 32'(sz);
		end
		// Usually grow the last chunk so that the file clears the stream header.
		if (total <= {16'd0, reg_stream_hdr} && $urandom_range(0, 3) != 0) begin
			need = int'(reg_stream_hdr) - int'(total) + 1 + int'(sizes[n-1]);
			if (need <= max_pay) begin
				total += 32'(need) - {16'd0, sizes[n-1]};
				sizes[n-1] = 16'(need);
			end
		end
		sess = $urandom;
		if (sess == '0) begin
			sess = 32'd1;
		end
		count = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(n);
		flaw_at = ($urandom_range(0, 99) < 25) ? $urandom_range(0, n - 1) : -1;
		flaw = flaw_t'($urandom_range(0, FLAW_TAIL));
		offset = '0;
		for (int k = 0; k < n; k++) begin
			if (k == flaw_at && flaw == FLAW_TAIL) begin
				break;
			end
			it = make_slot(sess, total, offset, sizes[k], 16'(k), count, k == 0, k == n - 1);
			if (k == flaw_at) begin
				case (flaw)
					FLAW_VERSION: it.version ^= 8'(1 << $urandom_range(0, 7));
					FLAW_HDR_SIZE: it.header_size_field ^= 16'(1 << $urandom_range(0, 15));
					FLAW_ZERO_PAY: it.payload_length = '0;
					FLAW_BIG_PAY: begin
						if (reg_payload_max != 16'hFFFF) begin
							it.payload_length = reg_payload_max + 16'd1;
						end
					end
					FLAW_PAY_FIT: it.slot_len = 16'(int'(reg_hdr_bytes) + int'(sizes[k]) - 1);
					FLAW_NAME: it.name_length = 8'($urandom_range(24, 255));
					FLAW_ZERO_SESS: it.session = '0;
					FLAW_CRC: it.side_bits[SIDE_CRC_OK] = 1'b0;
					FLAW_SESSION: it.session ^= 32'(1) << $urandom_range(0, 31);
					FLAW_TOTAL: it.stream_total ^= 32'(1) << $urandom_range(0, 31);
					FLAW_COUNT: it.chunk_total ^= 16'(1 << $urandom_range(0, 15));
					FLAW_OFFSET: it.chunk_offset += 32'($urandom_range(1, 1000));
					FLAW_INDEX: it.chunk_index ^= 16'(1 << $urandom_range(0, 15));
					FLAW_END_FLIP: it.side_bits[SIDE_END] = ~it.side_bits[SIDE_END];
					FLAW_START_FLIP: it.side_bits[SIDE_START] = ~it.side_bits[SIDE_START];
					FLAW_UNROUTED: it.side_bits[SIDE_ROUTABLE] = 1'b0;
					FLAW_TOO_SHORT: begin
						if (reg_hdr_bytes != '0) begin
							it.slot_len = 16'($urandom_range(0, int'(reg_hdr_bytes) - 1));
						end
					end
					FLAW_ABORT: push_item(abort_item(1'($urandom_range(0, 1))));
					default: ;
				endcase
			end
			push_item(it);
			offset += {16'd0, sizes[k]};
		end
	endtask

	// Mostly well-formed files, with aborts and noise mixed in.
	task automatic queue_traffic(int n);
		int target;
		int pick;
		target = items_made + n;
		while (items_made < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				queue_file();
			end else if (pick < 82) begin
				push_item(abort_item(1'($urandom_range(0, 1))));
			end else begin
				push_item(noise_item());
			end
		end
	endtask

	// Configuration
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_EXPECTED_VERSION: reg_version = val[7:0];
			CFG_HEADER_BYTES: reg_hdr_bytes = val[15:0];
			CFG_PAYLOAD_LIMIT: reg_payload_max = val[15:0];
			CFG_FILE_SIZE_LIMIT: reg_file_max = val;
			CFG_STREAM_HEADER_LEN: reg_stream_hdr = val[15:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [7:0] ver, logic [15:0] hdr, logic [15:0] pay,
			logic [31:0] file_max, logic [15:0] stream_hdr);
		write_reg(CFG_EXPECTED_VERSION, {24'd0, ver});
		write_reg(CFG_HEADER_BYTES, {16'd0, hdr});
		write_reg(CFG_PAYLOAD_LIMIT, {16'd0, pay});
		write_reg(CFG_FILE_SIZE_LIMIT, file_max);
		write_reg(CFG_STREAM_HEADER_LEN, {16'd0, stream_hdr});
	endtask

	// Waits until every item is in and every result out, then a short pause.
	task automatic wait_idle();
		while (slot_items.size() != 0 || in_valid || pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Checking
	task automatic report_mismatch(string msg);
		$display("%0t: result %0d: %s", $realtime, result_num, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	// Source: presents items from the pending queue in bursts with gaps between.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				pending_results.push_back(judge_item(in_data));
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (slot_items.size() != 0) begin
					in_data <= slot_items.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 150 : 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Sink: switches between no stall, random stall and a repeating mask.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			drain_left = 0;
		end else begin
			if (drain_left == 0) begin
				drain_mode = drain_mode_t'($urandom_range(0, DRAIN_PATTERN));
				drain_left = $urandom_range(20, 200);
				drain_mask = 8'($urandom) | 8'h01;
			end else begin
				drain_left--;
			end
			drain_beat <= drain_beat + 3'd1;
			case (drain_mode)
				DRAIN_FULL: out_ready <= 1'b1;
				DRAIN_RANDOM: out_ready <= ($urandom_range(0, 99) >= 40);
				default: out_ready <= drain_mask[drain_beat];
			endcase
		end
	end

	// Result check against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result arrived with no item outstanding");
			end else begin
				out_item_t want;
				want = pending_results.pop_front();
				compare_field("verdict", 32'(out_data.verdict), 32'(want.verdict));
				compare_field("reason", 32'(out_data.reason), 32'(want.reason));
				compare_field("open_file_dropped", 32'(out_data.open_file_dropped),
					32'(want.open_file_dropped));
				compare_field("first_chunk", 32'(out_data.first_chunk), 32'(want.first_chunk));
				compare_field("file_complete", 32'(out_data.file_complete),
					32'(want.file_complete));
				compare_field("slot_count", out_data.slot_count, want.slot_count);
				compare_field("good_file_count", out_data.good_file_count,
					want.good_file_count);
				compare_field("dropped_file_count", out_data.dropped_file_count,
					want.dropped_file_count);
				compare_field("unrouted_count", out_data.unrouted_count, want.unrouted_count);
			end
			result_num++;
		end
	end

	// Stimulus: directed cases at reset values, then random traffic per setting.
	initial begin
		in_item_t    it;
		logic [31:0] sa;
		logic [31:0] sb;
		logic [31:0] cap;
		while (!arst_n) begin
			@(posedge clk);
		end
		sa = 32'hA5C3_0011;
		sb = 32'h5A3C_0022;
		cap = reg_file_max + {16'd0, reg_stream_hdr};

		// Short slot, continuation with nothing open, start that cannot be routed.
		it = make_slot(sa, 100, 0, 60, 0, 2, 1'b1, 1'b0);
		it.slot_len = '0;
		push_item(it);
		push_item(make_slot(sa, 100, 60, 40, 1, 2, 1'b0, 1'b1));
		it = make_slot(sa, 100, 0, 60, 0, 2, 1'b1, 1'b0);
		it.side_bits[SIDE_ROUTABLE] = 1'b0;
		push_item(it);
		// Starts that are ignored: nonzero offset, total at the stream header, total past the cap.
		push_item(make_slot(sa, 100, 8, 60, 0, 2, 1'b1, 1'b0));
		push_item(make_slot(sa, {16'd0, reg_stream_hdr}, 0, 20, 0, 2, 1'b1, 1'b0));
		push_item(make_slot(sa, cap + 32'd1, 0, 60, 0, 2, 1'b1, 1'b0));
		// Largest accepted total, then an abort that does not count the drop.
		push_item(make_slot(sa, cap, 0, reg_payload_max, 0, 9, 1'b1, 1'b0));
		push_item(abort_item(1'b0));
		// A clean two-chunk file.
		push_item(make_slot(sa, 100, 0, 60, 0, 2, 1'b1, 1'b0));
		push_item(make_slot(sa, 100, 60, 40, 1, 2, 1'b0, 1'b1));
		// Start while open, then an identity break.
		push_item(make_slot(sb, 300, 0, 100, 0, 3, 1'b1, 1'b0));
		push_item(make_slot(sa, 300, 0, 100, 0, 3, 1'b1, 1'b0));
		push_item(make_slot(sb, 300, 100, 100, 1, 3, 1'b0, 1'b0));
		// Out of order, overrun, end too early, end missing, single-chunk file.
		push_item(make_slot(sa, 300, 0, 100, 0, 3, 1'b1, 1'b0));
		push_item(make_slot(sa, 300, 100, 100, 5, 3, 1'b0, 1'b0));
		push_item(make_slot(sa, 200, 0, 100, 0, 2, 1'b1, 1'b0));
		push_item(make_slot(sa, 200, 100, 150, 1, 2, 1'b0, 1'b1));
		push_item(make_slot(sa, 200, 0, 100, 0, 2, 1'b1, 1'b1));
		push_item(make_slot(sa, 100, 0, 100, 0, 1, 1'b1, 1'b0));
		push_item(make_slot(sa, 100, 0, 100, 0, 1, 1'b1, 1'b1));
		// Header failures, the first of them while a file is open.
		push_item(make_slot(sa, 300, 0, 100, 0, 3, 1'b1, 1'b0));
		it = make_slot(sa, 300, 100, 100, 1, 3, 1'b0, 1'b0);
		it.version = ~reg_version;
		push_item(it);
		it = make_slot(sa, 300, 0, 100, 0, 3, 1'b1, 1'b0);
		it.payload_length = '0;
		push_item(it);
		it.payload_length = reg_payload_max + 16'd1;
		push_item(it);
		it = make_slot(sa, 300, 0, 100, 0, 3, 1'b1, 1'b0);
		it.name_length = NAME_LIMIT + 8'd1;
		push_item(it);
		it.name_length = '0;
		it.session = '0;
		push_item(it);
		it.session = sa;
		it.side_bits[SIDE_CRC_OK] = 1'b0;
		push_item(it);
		// Abort that counts an open file.
		push_item(make_slot(sb, 300, 0, 100, 0, 3, 1'b1, 1'b0));
		push_item(abort_item(1'b1));
		queue_traffic(150);
		wait_idle();

		// Moderate random settings.
		write_all(8'($urandom), 16'($urandom_range(0, 200)), 16'($urandom_range(1, 8000)),
			32'($urandom_range(100, 100000)), 16'($urandom_range(0, 60)));
		queue_traffic(180);
		wait_idle();

		// Low extremes: no file can ever open.
		write_all(8'd0, 16'd0, 16'd1, 32'd0, 16'd0);
		queue_traffic(40);
		wait_idle();

		// One-byte chunks with a tiny file limit.
		write_reg(CFG_FILE_SIZE_LIMIT, 32'd5);
		queue_traffic(60);
		wait_idle();

		// Largest header size: no full slot can pass the payload fit.
		write_all(8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		queue_traffic(25);
		wait_idle();

		// High extremes with room for payloads; the total may reach its top value.
		write_reg(CFG_HEADER_BYTES, 32'd16);
		push_item(make_slot(sa, 32'hFFFF_FFFF, 0, 16'd65519, 0, 16'hFFFF, 1'b1, 1'b0));
		push_item(abort_item(1'b1));
		queue_traffic(150);
		wait_idle();

		// A payload limit of zero rejects every slot.
		write_reg(CFG_PAYLOAD_LIMIT, 32'd0);
		queue_traffic(25);
		wait_idle();

		// Back to the power-on values.
		write_all(RST_EXPECTED_VERSION, RST_HEADER_BYTES, RST_PAYLOAD_LIMIT,
			RST_FILE_SIZE_LIMIT, RST_STREAM_HEADER_LEN);
		queue_traffic(120);
		wait_idle();
		repeat (10) @(posedge clk);

		if (pending_results.size() != 0) begin
			report_mismatch("predicted results never arrived");
		end
		if (mismatch_count == 0) begin
			$display("** chunk_stream_continuity_checker_unit: PASSED **");
		end else begin
			$display("** chunk_stream_continuity_checker_unit: FAILED **");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#3200000;
		$display("** chunk_stream_continuity_checker_unit: FAILED **");
		$finish;
	end

endmodule

### chunk_stream_continuity_checker_unit.f
src/cscc_pkg.sv
src/cscc_front.sv
src/cscc_queue.sv
src/cscc_back.sv
src/chunk_stream_continuity_checker_unit.sv
bench/chunk_stream_continuity_checker_unit_tb.sv
